/* sv/ifmt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ifmt_pkg;

	// conversion kinds
	localparam logic [2:0] OP_DEC  = 3'd0;
	localparam logic [2:0] OP_HEX  = 3'd1;
	localparam logic [2:0] OP_BIN  = 3'd2;
	localparam logic [2:0] OP_PTR  = 3'd3;
	localparam logic [2:0] OP_CHAR = 3'd4;

	// digit register: ten BCD digits, also holds a 32-bit value MSB-aligned
	localparam int unsigned BCD_DIGITS = 10;
	localparam int unsigned DIG_W      = 4 * BCD_DIGITS;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_X     = 8'h78;

	typedef logic [DIG_W-1:0] dig_t;

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {4'd0, d};
		end else begin
			c = 8'h61 + {4'd0, d - 4'd10};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* sv/ifmt_dabble_step.sv */
`timescale 1ns / 1ps
`default_nettype none

// One shift-and-add-3 step of binary to BCD conversion.
module ifmt_dabble_step (
	input  wire ifmt_pkg::dig_t bcd_in,
	input  wire                 bit_in,
	output ifmt_pkg::dig_t      bcd_out
);

	ifmt_pkg::dig_t adj;

	always_comb begin
		for (int i = 0; i < ifmt_pkg::BCD_DIGITS; i++) begin
			if (bcd_in[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_in[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_in[4*i +: 4];
			end
		end
	end

	assign bcd_out = {adj[ifmt_pkg::DIG_W-2:0], bit_in};

endmodule

`default_nettype wire

/* sv/integer_to_ascii_field_formatter.sv */
`timescale 1ns / 1ps
`default_nettype none

// Integer to ASCII field formatter.
// Input channel (in_valid / in_stall) takes one conversion request: kind,
// 32-bit value, minimum width, zero-fill and left-justify flags. Output channel
// (out_valid / out_stall) returns the text one character per transaction,
// with last set on the final character. Unused kinds and an empty result
// (char kind with byte zero and width zero) produce no transactions.
// One request at a time: in_stall is high from acceptance until the final
// character has been loaded into the output register.
// Steps per request: decimal first runs the BCD shift-add unit over all 32 bits.
// Leading zero stripping then drops leading zero digits, keeping at least one
// (from 10 digits for decimal, 32 for binary, 8 for hex/pointer; char skips it),
// then a setup step computes the padding, then the characters are emitted (the
// larger of text length and saturated width).
// A stalled receiver simply holds the current character; generation waits.
// Reset clears the sequencer and the output valid; nothing is pending after.
module integer_to_ascii_field_formatter #(
	parameter int unsigned MAX_FIELD_WIDTH = 63
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [2:0] operation,
	input  wire [31:0] value,
	input  wire  [5:0] min_width,
	input  wire        zero_fill,
	input  wire        left_justify,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [7:0] character,
	output logic       last
);

	localparam logic [5:0] FW_MAX = 6'(MAX_FIELD_WIDTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_NORM,
		S_SETUP,
		S_EMIT
	} state_t;

	state_t         state_q;
	logic [4:0]     cnt_q;
	ifmt_pkg::dig_t dig_q;
	logic [31:0]    val_q;
	logic [5:0]     ndig_q;
	logic [5:0]     pre_q;
	logic [1:0]     pfx_q;
	logic [5:0]     post_q;
	logic [5:0]     fw_q;
	logic [2:0]     op_q;
	logic           lj_q;
	logic           zf_q;
	logic           out_valid_q;
	logic [7:0]     char_q;
	logic           last_q;

	ifmt_pkg::dig_t dabble;
	logic           in_acc;
	logic           advance;
	logic           is_bin;
	logic [3:0]     top_digit;
	ifmt_pkg::dig_t dig_shifted;
	logic [5:0]     fw_sat;
	logic [5:0]     txt_len;
	logic [5:0]     total;
	logic [5:0]     pads;
	logic [6:0]     remaining;

	ifmt_dabble_step u_dabble (
		.bcd_in  (dig_q),
		.bit_in  (val_q[31]),
		.bcd_out (dabble)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign advance   = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

	assign is_bin      = (op_q == ifmt_pkg::OP_BIN);
	assign top_digit   = is_bin ? {3'd0, dig_q[ifmt_pkg::DIG_W-1]}
	                            : dig_q[ifmt_pkg::DIG_W-1 -: 4];
	assign dig_shifted = is_bin ? {dig_q[ifmt_pkg::DIG_W-2:0], 1'b0}
	                            : {dig_q[ifmt_pkg::DIG_W-5:0], 4'd0};

	assign fw_sat  = (min_width > FW_MAX) ? FW_MAX : min_width;
	assign txt_len = ndig_q + ((op_q == ifmt_pkg::OP_PTR) ? 6'd2 : 6'd0);
	assign total   = (fw_q > txt_len) ? fw_q : txt_len;
	assign pads    = total - txt_len;
	assign remaining = {1'b0, pre_q} + {5'd0, pfx_q} + {1'b0, ndig_q} + {1'b0, post_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			ndig_q      <= '0;
			pre_q       <= '0;
			pfx_q       <= '0;
			post_q      <= '0;
		end else begin
			// in emission the output register is reloaded below
			if (out_valid_q && !out_stall && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						op_q  <= operation;
						fw_q  <= fw_sat;
						lj_q  <= left_justify;
						zf_q  <= zero_fill;
						val_q <= value;
						cnt_q <= '0;
						case (operation)
							ifmt_pkg::OP_DEC: begin
								dig_q   <= '0;
								state_q <= S_CONV;
							end
							ifmt_pkg::OP_HEX, ifmt_pkg::OP_PTR: begin
								dig_q   <= {value, 8'd0};
								ndig_q  <= 6'd8;
								state_q <= S_NORM;
							end
							ifmt_pkg::OP_BIN: begin
								dig_q   <= {value, 8'd0};
								ndig_q  <= 6'd32;
								state_q <= S_NORM;
							end
							ifmt_pkg::OP_CHAR: begin
								dig_q   <= {value[7:0], 32'd0};
								ndig_q  <= (value[7:0] != 8'd0) ? 6'd1 : 6'd0;
								state_q <= S_SETUP;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_CONV: begin
					dig_q <= dabble;
					val_q <= {val_q[30:0], 1'b0};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						ndig_q  <= 6'(ifmt_pkg::BCD_DIGITS);
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (ndig_q > 6'd1 && top_digit == 4'd0) begin
						dig_q  <= dig_shifted;
						ndig_q <= ndig_q - 6'd1;
					end else begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					pre_q   <= lj_q ? 6'd0 : pads;
					post_q  <= lj_q ? pads : 6'd0;
					pfx_q   <= (op_q == ifmt_pkg::OP_PTR) ? 2'd2 : 2'd0;
					state_q <= (total == 6'd0) ? S_IDLE : S_EMIT;
				end
				S_EMIT: begin
					if (advance) begin
						out_valid_q <= 1'b1;
						last_q      <= (remaining == 7'd1);
						if (pre_q != 6'd0) begin
							char_q <= zf_q ? ifmt_pkg::CH_ZERO : ifmt_pkg::CH_SPACE;
							pre_q  <= pre_q - 6'd1;
						end else if (pfx_q != 2'd0) begin
							char_q <= (pfx_q == 2'd2) ? ifmt_pkg::CH_ZERO : ifmt_pkg::CH_X;
							pfx_q  <= pfx_q - 2'd1;
						end else if (ndig_q != 6'd0) begin
							if (op_q == ifmt_pkg::OP_CHAR) begin
								char_q <= dig_q[ifmt_pkg::DIG_W-1 -: 8];
							end else begin
								char_q <= ifmt_pkg::hex_char(top_digit);
							end
							dig_q  <= dig_shifted;
							ndig_q <= ndig_q - 6'd1;
						end else begin
							char_q <= ifmt_pkg::CH_SPACE;
							post_q <= post_q - 6'd1;
						end
						if (remaining == 7'd1) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a decimal request always starts in the BCD unit
	a_dec_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && operation == ifmt_pkg::OP_DEC) |=> (state_q == S_CONV))
		else $error("decimal request did not start conversion");

	// the sequencer never sits in emission with nothing left to send
	a_emit_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (remaining != 7'd0))
		else $error("emission with no characters pending");

	// digit count never exceeds a binary word
	a_ndig_max: assert property (@(posedge clk) disable iff (!arst_n)
		ndig_q <= 6'd32)
		else $error("digit count out of range");

	// leading-zero stripping keeps at least one digit
	a_norm_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NORM) |-> (ndig_q != 6'd0))
		else $error("all digits stripped");

	// a character is only loaded while the previous one is taken or absent
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> $stable(char_q))
		else $error("pending character overwritten");

endmodule

`default_nettype wire
